/* src/double_columnar_transposition_macros.svh */
// Assertion macros used by the checker file of the transposition block.
// Depends on nothing; each macro expands to one labelled concurrent assertion.
`ifndef DOUBLE_COLUMNAR_TRANSPOSITION_MACROS_SVH
`define DOUBLE_COLUMNAR_TRANSPOSITION_MACROS_SVH

// Assertion that is switched off while reset is high.
`define DCT_ASSERT(lbl, clk, rst, prop, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Assertion that also holds across reset.
`define DCT_ASSERT_ALWAYS(lbl, clk, prop, msg) \
   lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

/* src/dct_pkg.sv */
// Shared types and constants of the double columnar transposition block.
// Depends on nothing; imported by every module of the block but dct_ram.
package dct_pkg;

   localparam int CHAR_W     = 8;
   localparam int KEY_LEN_W  = 4;
   localparam int CSR_DATA_W = 64;
   localparam int CSR_IDX_W  = 2;

   localparam logic [CHAR_W-1:0] PAD_CHAR = 8'h58;

   localparam logic [CSR_IDX_W-1:0] CSR_FIRST_KEY_CHARS   = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_FIRST_KEY_LENGTH  = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_SECOND_KEY_CHARS  = 2'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_SECOND_KEY_LENGTH = 2'd3;

   typedef struct packed {
      logic [CHAR_W-1:0] text_char;
      logic              text_end;
   } req_type;

   typedef struct packed {
      logic [CHAR_W-1:0] cipher_char;
      logic              cipher_end;
      logic              overflow;
   } rsp_type;

   typedef enum logic [2:0] {
      ST_LOAD,
      ST_PASS1,
      ST_FLUSH,
      ST_PASS2,
      ST_DRAIN
   } state_type;

endpackage

/* src/dct_ram.sv */
// Generic single-port-write, single-port-read RAM with registered read data.
// Depends on nothing.
module dct_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 48
) (
   input  logic                                    clock,
   input  logic                                    we,
   input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
   input  logic [WIDTH-1:0]                        wdata,
   input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
   output logic [WIDTH-1:0]                        rdata
);

   logic [WIDTH-1:0] mem_ff [DEPTH];

   always_ff @(posedge clock) begin
      if (we) begin
         mem_ff[waddr] <= wdata;
      end
      rdata <= mem_ff[raddr];
   end

endmodule

/* src/dct_key_order.sv */
// Works out the column read-out order of one key: columns sorted by key byte,
// equal bytes by position. Depends on dct_pkg.
module dct_key_order
   import dct_pkg::*;
#(
   parameter int MAX_KEY = 8
) (
   input  logic                                                   clock,
   input  logic [CSR_DATA_W-1:0]                                  key_chars,
   input  logic [KEY_LEN_W-1:0]                                   key_length,
   output logic [MAX_KEY-1:0][(MAX_KEY > 1 ? $clog2(MAX_KEY) : 1)-1:0] order_ff,
   output logic [$clog2(MAX_KEY + 1)-1:0]                         cols_ff
);

   localparam int KIDX_W = (MAX_KEY > 1) ? $clog2(MAX_KEY) : 1;
   localparam int KLEN_W = $clog2(MAX_KEY + 1);

   logic [KLEN_W-1:0]                    cols_in;
   logic [MAX_KEY-1:0][KLEN_W-1:0]       rank;
   logic [MAX_KEY-1:0][KIDX_W-1:0]       order_in;

   // Zero length counts as one column, anything above the maximum saturates.
   always_comb begin
      if (key_length == '0) begin
         cols_in = KLEN_W'(1);
      end else if (key_length > KEY_LEN_W'(MAX_KEY)) begin
         cols_in = KLEN_W'(MAX_KEY);
      end else begin
         cols_in = KLEN_W'(key_length);
      end
   end

   // The rank of a column is the number of live columns that sort ahead of it.
   always_comb begin
      for (int i = 0; i < MAX_KEY; i++) begin
         rank[i] = '0;
         for (int j = 0; j < MAX_KEY; j++) begin
            if ((KLEN_W'(j) < cols_in) &&
                ((key_chars[8*j +: 8] < key_chars[8*i +: 8]) ||
                 ((key_chars[8*j +: 8] == key_chars[8*i +: 8]) && (j < i)))) begin
               rank[i] = rank[i] + KLEN_W'(1);
            end
         end
      end
   end

   always_comb begin
      for (int r = 0; r < MAX_KEY; r++) begin
         order_in[r] = '0;
         for (int i = 0; i < MAX_KEY; i++) begin
            if ((KLEN_W'(i) < cols_in) && (rank[i] == KLEN_W'(r))) begin
               order_in[r] = KIDX_W'(i);
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      order_ff <= order_in;
      cols_ff  <= cols_in;
   end

endmodule

/* src/double_columnar_transposition.sv */
// Double columnar transposition encipher.
// Plaintext enters on the req_ channel, one byte per item, one item per cycle
// while the block is loading. The item with text_end set closes the message;
// at most MAX_TEXT bytes are kept and later ones are dropped, which sets
// overflow on every result item of that message.
// After the closing item req_stall rises. The first key's grid, padded to full
// rows, is read out column by column into a second buffer at one byte per
// cycle, a flush state lets the last write settle, then the second key's grid
// is read out to rsp_ at one item per cycle while rsp_stall is low. The last
// result item carries cipher_end. A stalled result holds its value; the
// read-out pauses with it. req_stall falls again in the cycle after the last
// result reaches the output register.
// Reset (synchronous) empties the buffer, clears the drop flag and sets both
// key lengths to one. The user must see that keys are written on csr_ only
// while the block is idle; the block itself does not enforce this.
// Depends on dct_pkg, dct_ram and dct_key_order.
module double_columnar_transposition
   import dct_pkg::*;
#(
   parameter int MAX_TEXT = 48,
   parameter int MAX_KEY  = 8
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_stall,
   input  req_type               req_data,
   output logic                  rsp_valid,
   input  logic                  rsp_stall,
   output rsp_type               rsp_data,
   input  logic                  csr_we,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [CSR_DATA_W-1:0] csr_wdata
);

   localparam int KIDX_W    = (MAX_KEY > 1) ? $clog2(MAX_KEY) : 1;
   localparam int KLEN_W    = $clog2(MAX_KEY + 1);
   localparam int CNT_W     = $clog2(MAX_TEXT + 1);
   localparam int TA_W      = (MAX_TEXT > 1) ? $clog2(MAX_TEXT) : 1;
   localparam int MID_DEPTH = MAX_TEXT + MAX_KEY - 1;
   localparam int MA_W      = (MID_DEPTH > 1) ? $clog2(MID_DEPTH) : 1;
   localparam int POS_W     = $clog2(MAX_TEXT + 2 * MAX_KEY);

   // Configuration registers.
   logic [CSR_DATA_W-1:0] key1_chars_ff, key2_chars_ff;
   logic [KEY_LEN_W-1:0]  key1_len_ff, key2_len_ff;

   logic [MAX_KEY-1:0][KIDX_W-1:0] order1, order2, order_sel;
   logic [KLEN_W-1:0]              cols1, cols2, cols_sel;

   state_type state_ff, state_in;

   logic [CNT_W-1:0] count_ff, count_in;
   logic             dropped_ff, dropped_in;
   logic [POS_W-1:0] mid_count_ff, mid_count_in;

   logic [KIDX_W-1:0] r_ff, r_in;
   logic [POS_W-1:0]  base_ff, base_in;

   logic             s1_valid_ff, s1_valid_in;
   logic             s1_pad_ff, s1_last_ff, s1_ovf_ff, s1_pass2_ff;
   logic [POS_W-1:0] s1_pos_ff, mid_raddr;

   logic             rsp_valid_ff, rsp_valid_in;
   rsp_type          rsp_data_ff;

   // Control from the state machine.
   logic load_en, walk_en, walk_rst, clear_msg, pass2;

   logic             load_accept, store_full, store_we;
   logic [POS_W-1:0] len_sel, pos, base_next;
   logic             col_done, last_issue, out_free, s1_go, mid_we;
   logic [CHAR_W-1:0] text_rdata, mid_rdata, mid_wdata;

   always_ff @(posedge clock) begin
      if (reset) begin
         key1_chars_ff <= '0;
         key1_len_ff   <= KEY_LEN_W'(1);
         key2_chars_ff <= '0;
         key2_len_ff   <= KEY_LEN_W'(1);
      end else if (csr_we) begin
         unique case (csr_index)
            CSR_FIRST_KEY_CHARS:   key1_chars_ff <= csr_wdata;
            CSR_FIRST_KEY_LENGTH:  key1_len_ff   <= csr_wdata[KEY_LEN_W-1:0];
            CSR_SECOND_KEY_CHARS:  key2_chars_ff <= csr_wdata;
            CSR_SECOND_KEY_LENGTH: key2_len_ff   <= csr_wdata[KEY_LEN_W-1:0];
            default: ;
         endcase
      end
   end

   dct_key_order #(.MAX_KEY(MAX_KEY)) u_order1 (
      .clock      (clock),
      .key_chars  (key1_chars_ff),
      .key_length (key1_len_ff),
      .order_ff   (order1),
      .cols_ff    (cols1)
   );

   dct_key_order #(.MAX_KEY(MAX_KEY)) u_order2 (
      .clock      (clock),
      .key_chars  (key2_chars_ff),
      .key_length (key2_len_ff),
      .order_ff   (order2),
      .cols_ff    (cols2)
   );

   // Column walker, shared by both passes. Within a column the row base steps
   // by the column count while the next base stays below the grid length.
   assign pass2     = (state_ff == ST_PASS2);
   assign order_sel = pass2 ? order2 : order1;
   assign cols_sel  = pass2 ? cols2 : cols1;
   assign len_sel   = pass2 ? mid_count_ff : POS_W'(count_ff);
   assign pos       = base_ff + POS_W'(order_sel[r_ff]);
   assign base_next = base_ff + POS_W'(cols_sel);
   assign col_done  = (base_next >= len_sel);
   assign last_issue = col_done && ((KLEN_W'(r_ff) + KLEN_W'(1)) == cols_sel);

   assign out_free = !rsp_valid_ff || !rsp_stall;
   assign s1_go    = s1_valid_ff && (!s1_pass2_ff || out_free);

   // State machine: next state.
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_LOAD: begin
            if (load_accept && req_data.text_end) state_in = ST_PASS1;
         end
         ST_PASS1: begin
            if (last_issue) state_in = ST_FLUSH;
         end
         ST_FLUSH: begin
            state_in = ST_PASS2;
         end
         ST_PASS2: begin
            if (walk_en && last_issue) state_in = ST_DRAIN;
         end
         ST_DRAIN: begin
            if (!s1_valid_ff) state_in = ST_LOAD;
         end
         default: state_in = ST_LOAD;
      endcase
   end

   // State machine: outputs.
   always_comb begin
      load_en   = 1'b0;
      walk_en   = 1'b0;
      walk_rst  = 1'b0;
      clear_msg = 1'b0;
      unique case (state_ff)
         ST_LOAD: begin
            load_en  = 1'b1;
            walk_rst = 1'b1;
         end
         ST_PASS1: begin
            walk_en = 1'b1;
         end
         ST_FLUSH: begin
            walk_rst = 1'b1;
         end
         ST_PASS2: begin
            // A new read may start only if no item is in flight or the item in flight can move on.
            walk_en = !s1_valid_ff || s1_go;
         end
         ST_DRAIN: begin
            clear_msg = !s1_valid_ff;
         end
         default: ;
      endcase
   end

   assign req_stall   = !load_en;
   assign load_accept = load_en && req_valid;
   assign store_full  = (count_ff == CNT_W'(MAX_TEXT));
   assign store_we    = load_accept && !store_full;

   always_comb begin
      count_in   = count_ff;
      dropped_in = dropped_ff;
      if (clear_msg) begin
         count_in   = '0;
         dropped_in = 1'b0;
      end else if (store_we) begin
         count_in = count_ff + CNT_W'(1);
      end else if (load_accept) begin
         dropped_in = 1'b1;
      end
   end

   always_comb begin
      r_in    = r_ff;
      base_in = base_ff;
      if (walk_rst) begin
         r_in    = '0;
         base_in = '0;
      end else if (walk_en && !last_issue) begin
         if (col_done) begin
            r_in    = r_ff + KIDX_W'(1);
            base_in = '0;
         end else begin
            base_in = base_next;
         end
      end
   end

   assign s1_valid_in = walk_en || (s1_valid_ff && !s1_go);

   // First pass fills the intermediate buffer in read-out order.
   assign mid_we    = s1_valid_ff && !s1_pass2_ff;
   assign mid_wdata = s1_pad_ff ? PAD_CHAR : text_rdata;

   // While an item waits for the output register, its byte is read again so
   // that the read data still belongs to it when it moves on.
   assign mid_raddr = walk_en ? pos : s1_pos_ff;

   always_comb begin
      mid_count_in = mid_count_ff;
      if (load_accept && req_data.text_end) begin
         mid_count_in = '0;
      end else if (mid_we) begin
         mid_count_in = mid_count_ff + POS_W'(1);
      end
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (s1_go && s1_pass2_ff) begin
         rsp_valid_in = 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_LOAD;
         count_ff     <= '0;
         dropped_ff   <= 1'b0;
         s1_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         dropped_ff   <= dropped_in;
         s1_valid_ff  <= s1_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      r_ff         <= r_in;
      base_ff      <= base_in;
      mid_count_ff <= mid_count_in;
      if (walk_en) begin
         s1_pad_ff   <= (pos >= len_sel);
         s1_last_ff  <= last_issue;
         s1_ovf_ff   <= dropped_ff;
         s1_pass2_ff <= pass2;
         s1_pos_ff   <= pos;
      end
      if (s1_go && s1_pass2_ff) begin
         rsp_data_ff.cipher_char <= s1_pad_ff ? PAD_CHAR : mid_rdata;
         rsp_data_ff.cipher_end  <= s1_last_ff;
         rsp_data_ff.overflow    <= s1_ovf_ff;
      end
   end

   dct_ram #(.WIDTH(CHAR_W), .DEPTH(MAX_TEXT)) u_text_store (
      .clock (clock),
      .we    (store_we),
      .waddr (count_ff[TA_W-1:0]),
      .wdata (req_data.text_char),
      .raddr (pos[TA_W-1:0]),
      .rdata (text_rdata)
   );

   dct_ram #(.WIDTH(CHAR_W), .DEPTH(MID_DEPTH)) u_mid_store (
      .clock (clock),
      .we    (mid_we),
      .waddr (mid_count_ff[MA_W-1:0]),
      .wdata (mid_wdata),
      .raddr (mid_raddr[MA_W-1:0]),
      .rdata (mid_rdata)
   );

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

endmodule

/* src/dct_checker.sv */
// Port-level checks of the double columnar transposition block, bound to the
// top level. Depends on dct_pkg and the assertion macro header.
`include "double_columnar_transposition_macros.svh"

module dct_checker
   import dct_pkg::*;
(
   input logic    clock,
   input logic    reset,
   input logic    req_valid,
   input logic    req_stall,
   input req_type req_data,
   input logic    rsp_valid,
   input logic    rsp_stall,
   input rsp_type rsp_data
);

   // A result that waits must keep its value.
   `DCT_ASSERT(a_rsp_hold, clock, reset, rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_data), "stalled result item changed")

   // Leaving reset the block is ready to load and shows no result.
   `DCT_ASSERT_ALWAYS(a_reset_idle, clock, reset |=> !req_stall && !rsp_valid, "block not idle after reset")

   // A closing item starts the read-out, so loading pauses at once.
   `DCT_ASSERT(a_end_stalls, clock, reset, req_valid && !req_stall && req_data.text_end |=> req_stall, "input not stalled after closing item")

   // Loading only resumes once the last result of a message has been produced.
   `DCT_ASSERT(a_mid_msg_stall, clock, reset, rsp_valid && !rsp_data.cipher_end |-> req_stall, "input open while a message is still being read out")

endmodule

bind double_columnar_transposition dct_checker u_dct_checker (.*);

/* tb/double_columnar_transposition_test.sv */
// Self-checking testbench for the double columnar transposition encipher block.
// Plaintext items go in on req_, and every cipher item on rsp_ is checked against
// a predictor of both transpositions held here. Depends on dct_pkg and the RTL.
module double_columnar_transposition_test;
   timeunit 1ns;
   timeprecision 1ps;

   import dct_pkg::*;

   localparam int TEXT_CAP = 48;
   localparam int KEY_CAP  = 8;

   typedef logic [CHAR_W-1:0] byte_queue_type[$];

   logic                  clock     = 1'b0;
   logic                  reset     = 1'b1;
   logic                  req_valid = 1'b0;
   logic                  req_stall;
   req_type               req_data  = '0;
   logic                  rsp_valid;
   logic                  rsp_stall = 1'b0;
   rsp_type               rsp_data;
   logic                  csr_we    = 1'b0;
   logic [CSR_IDX_W-1:0]  csr_index = CSR_FIRST_KEY_CHARS;
   logic [CSR_DATA_W-1:0] csr_wdata = '0;

   // Predictor state: the buffered message and our copy of the key registers.
   byte_queue_type        plain_text;
   logic                  plain_dropped = 1'b0;
   logic [63:0]           first_key     = '0;
   logic [63:0]           second_key    = '0;
   logic [3:0]            first_len     = 4'd1;
   logic [3:0]            second_len    = 4'd1;
   rsp_type               cipher_expected[$];

   int                    fault_count    = 0;
   bit                    idling_enabled = 1'b1;
   int                    hold_request   = 0;
   int                    hold_left      = 0;
   int                    burst_left     = 0;

   double_columnar_transposition #(
      .MAX_TEXT(TEXT_CAP),
      .MAX_KEY (KEY_CAP)
   ) DUT (
      .clock    (clock),
      .reset    (reset),
      .req_valid(req_valid),
      .req_stall(req_stall),
      .req_data (req_data),
      .rsp_valid(rsp_valid),
      .rsp_stall(rsp_stall),
      .rsp_data (rsp_data),
      .csr_we   (csr_we),
      .csr_index(csr_index),
      .csr_wdata(csr_wdata)
   );

   always #4 clock = ~clock;

   initial begin
      #50_000_000;
      $display("Regression FAIL");
      $finish;
   end

   // One columnar pass: columns are taken in ascending order of their key byte,
   // ties broken by position, and short rows are filled with the pad byte.
   function automatic byte_queue_type columnar_pass(input byte_queue_type src,
                                                    input logic [63:0] key,
                                                    input logic [3:0] len_field);
      int             cols;
      int             rows;
      int             rank;
      int             pos;
      int             col_at_rank[KEY_CAP];
      byte_queue_type dst;
      if (len_field == 0) cols = 1;
      else if (len_field > KEY_CAP) cols = KEY_CAP;
      else cols = len_field;
      for (int c = 0; c < cols; c++) begin
         rank = 0;
         for (int j = 0; j < cols; j++)
            if (key[8*j +: 8] < key[8*c +: 8] || (key[8*j +: 8] == key[8*c +: 8] && j < c))
               rank++;
         col_at_rank[rank] = c;
      end
      rows = (src.size() + cols - 1) / cols;
      for (int r = 0; r < cols; r++) begin
         for (int row = 0; row < rows; row++) begin
            pos = row * cols + col_at_rank[r];
            dst = {dst, ((pos < src.size()) ? src[pos] : PAD_CHAR)};
         end
      end
      return dst;
   endfunction

   function automatic byte_queue_type random_text(input int count);
      byte_queue_type text;
      repeat (count) text = {text, 8'($urandom)};
      return text;
   endfunction

   function automatic byte_queue_type random_message();
      int pick;
      int count;
      pick = $urandom_range(0, 19);
      if (pick == 0) count = $urandom_range(TEXT_CAP + 1, TEXT_CAP + 8);
      else if (pick < 4) count = $urandom_range(17, TEXT_CAP);
      else count = $urandom_range(1, 16);
      return random_text(count);
   endfunction

   // Mostly a small alphabet so that equal key characters turn up often.
   function automatic logic [63:0] random_key();
      logic [63:0] key;
      for (int i = 0; i < KEY_CAP; i++)
         key[8*i +: 8] = ($urandom_range(0, 2) == 0) ? 8'($urandom)
                                                      : 8'h41 + 8'($urandom_range(0, 3));
      return key;
   endfunction

   function automatic logic [3:0] random_key_length();
      if ($urandom_range(0, 9) == 0)
         return ($urandom_range(0, 1) == 0) ? 4'd0 : 4'($urandom_range(KEY_CAP + 1, 15));
      return 4'($urandom_range(1, KEY_CAP));
   endfunction

   // Receiver pacing: a long hold when asked for, otherwise random stall bursts.
   always @(negedge clock) begin
      if (hold_request > 0) begin
         hold_left    = hold_request;
         hold_request = 0;
      end
      if (hold_left > 0) begin
         hold_left--;
         rsp_stall <= 1'b1;
      end else if (burst_left > 0) begin
         burst_left--;
         rsp_stall <= 1'b1;
      end else if (idling_enabled && $urandom_range(0, 7) == 0) begin
         burst_left = $urandom_range(0, 17);
         rsp_stall <= 1'b1;
      end else begin
         rsp_stall <= 1'b0;
      end
   end

   always @(posedge clock) begin : cipher_check
      rsp_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (cipher_expected.size() == 0) begin
            $error("cipher item %h arrived with none expected", rsp_data);
            fault_count++;
         end else begin
            want = cipher_expected.pop_front();
            if (rsp_data.cipher_char !== want.cipher_char) begin
               $error("cipher_char expected %h got %h", want.cipher_char,
                      rsp_data.cipher_char);
               fault_count++;
            end
            if (rsp_data.cipher_end !== want.cipher_end) begin
               $error("cipher_end expected %b got %b", want.cipher_end, rsp_data.cipher_end);
               fault_count++;
            end
            if (rsp_data.overflow !== want.overflow) begin
               $error("overflow expected %b got %b", want.overflow, rsp_data.overflow);
               fault_count++;
            end
         end
      end
   end

   // All tasks below are entered and left just after a falling edge. The valid
   // of an accepted item stays up until the next item or an idle replaces it.
   task automatic send_byte(input logic [CHAR_W-1:0] text_char, input logic text_end);
      int             gap;
      req_type        item;
      byte_queue_type mid;
      byte_queue_type fin;
      rsp_type        cipher;
      gap = (idling_enabled && $urandom_range(0, 5) == 0) ? $urandom_range(1, 18) : 0;
      item.text_char = text_char;
      item.text_end  = text_end;
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_valid <= 1'b1;
      req_data  <= item;
      do @(posedge clock); while (req_stall);
      if (plain_text.size() < TEXT_CAP) plain_text = {plain_text, item.text_char};
      else plain_dropped = 1'b1;
      if (item.text_end) begin
         mid = columnar_pass(plain_text, first_key, first_len);
         fin = columnar_pass(mid, second_key, second_len);
         foreach (fin[k]) begin
            cipher.cipher_char = fin[k];
            cipher.cipher_end  = (k == fin.size() - 1);
            cipher.overflow    = plain_dropped;
            cipher_expected    = {cipher_expected, cipher};
         end
         plain_text.delete();
         plain_dropped = 1'b0;
      end
      @(negedge clock);
   endtask

   task automatic send_message(input byte_queue_type text);
      foreach (text[i]) send_byte(text[i], i == text.size() - 1);
   endtask

   task automatic wait_drained();
      req_valid <= 1'b0;
      while (cipher_expected.size() != 0) @(posedge clock);
      repeat (8) @(posedge clock);
      @(negedge clock);
   endtask

   task automatic program_keys(input logic [63:0] key1, input logic [3:0] len1,
                               input logic [63:0] key2, input logic [3:0] len2);
      csr_we    <= 1'b1;
      csr_index <= CSR_FIRST_KEY_CHARS;
      csr_wdata <= key1;
      @(negedge clock);
      csr_index <= CSR_FIRST_KEY_LENGTH;
      csr_wdata <= CSR_DATA_W'(len1);
      @(negedge clock);
      csr_index <= CSR_SECOND_KEY_CHARS;
      csr_wdata <= key2;
      @(negedge clock);
      csr_index <= CSR_SECOND_KEY_LENGTH;
      csr_wdata <= CSR_DATA_W'(len2);
      @(negedge clock);
      csr_we <= 1'b0;
      first_key  = key1;
      first_len  = len1;
      second_key = key2;
      second_len = len2;
   endtask

   // With the reset keys both passes leave the text as it is.
   task automatic test_reset_keys();
      byte_queue_type text;
      text = '{8'h00};
      send_message(text);
      text = '{8'hFF, 8'h41, 8'h80};
      send_message(text);
   endtask

   task automatic test_extreme_bytes();
      byte_queue_type text;
      wait_drained();
      program_keys(64'hFF00_4B41_4B00_FF41, 4'd8, 64'h0000_0000_0042_4143, 4'd3);
      text = '{8'h00, 8'h01, 8'h7F, 8'h80, 8'hFE, 8'hFF, PAD_CHAR};
      send_message(text);
      text = '{8'hAA, 8'h55, 8'h0F, 8'hF0, 8'h12, 8'h34, 8'h56, 8'h78};
      send_message(text);
   endtask

   // A length of zero behaves as one, and lengths above eight as eight.
   task automatic test_key_length_limits();
      wait_drained();
      program_keys(random_key(), 4'd0, random_key(), 4'd15);
      send_message(random_text(11));
      wait_drained();
      program_keys(random_key(), 4'd15, random_key(), 4'd0);
      send_message(random_text(9));
   endtask

   // Exactly full, then a closing item that is itself dropped, then a long run.
   task automatic test_buffer_full();
      wait_drained();
      program_keys(random_key(), 4'd8, random_key(), 4'd7);
      send_message(random_text(TEXT_CAP));
      send_message(random_text(TEXT_CAP + 1));
      send_message(random_text(TEXT_CAP + 12));
   endtask

   task automatic test_random_keys(input int phases, input int items_per_phase);
      int             sent;
      byte_queue_type text;
      for (int p = 0; p < phases; p++) begin
         wait_drained();
         program_keys(random_key(), random_key_length(), random_key(), random_key_length());
         idling_enabled = ($urandom_range(0, 3) != 0);
         sent = 0;
         while (sent < items_per_phase) begin
            text = random_message();
            send_message(text);
            sent += text.size();
         end
      end
      idling_enabled = 1'b1;
   endtask

   // The receiver holds off while further messages are offered, so the block
   // fills and stalls its input; afterwards the sender waits for every result.
   task automatic test_backpressure();
      wait_drained();
      program_keys(random_key(), 4'd8, random_key(), 4'd8);
      send_message(random_text(20));
      hold_request = 300;
      for (int m = 0; m < 3; m++) send_message(random_text($urandom_range(5, 20)));
      wait_drained();
      send_message(random_text(12));
   endtask

   task automatic test_steady_stream(input int items);
      int             sent;
      byte_queue_type text;
      idling_enabled = 1'b0;
      wait_drained();
      program_keys(random_key(), random_key_length(), random_key(), random_key_length());
      sent = 0;
      while (sent < items) begin
         text = random_message();
         send_message(text);
         sent += text.size();
      end
   endtask

   initial begin : run_regression
      int settle;
      repeat (7) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      test_reset_keys();
      test_extreme_bytes();
      test_key_length_limits();
      test_buffer_full();
      test_random_keys(3, 40);
      test_backpressure();
      test_steady_stream(60);
      req_valid <= 1'b0;
      settle = 0;
      while (cipher_expected.size() != 0 && settle < 20000) begin
         @(posedge clock);
         settle++;
      end
      repeat (150) @(posedge clock);
      if (cipher_expected.size() != 0) begin
         $error("%0d cipher items never arrived", cipher_expected.size());
         fault_count++;
      end
      if (fault_count == 0) begin
         $display("Regression PASS");
      end else begin
         $display("Regression FAIL");
      end
      $finish;
   end

endmodule
